### src/rc_capacitance_meter_sequencer_assert.svh
// ----------------------------------------------------------------------------
// RC capacitance meter sequencer assertion macros
// Shared concurrent assertion forms clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef RC_CAPACITANCE_METER_SEQUENCER_ASSERT_SVH
`define RC_CAPACITANCE_METER_SEQUENCER_ASSERT_SVH

// Check an invariant on every clock edge outside reset.
`define RCCM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define RCCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rccm_pkg.sv
// ----------------------------------------------------------------------------
// RC capacitance meter package
// Widths, register indexes, reset values, sequencer step and phase codes.
// ----------------------------------------------------------------------------
package rccm_pkg;

   localparam int ADC_W      = 10;
   localparam int COUNT_W    = 24;
   localparam int LEVEL_W    = 10;
   localparam int SETTLE_W   = 16;
   localparam int WAIT_W     = 24;
   localparam int RECIP_W    = 32;
   localparam int ELAPSED_W  = 24;
   localparam int CAP_W      = 32;
   localparam int PHASE_W    = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = ELAPSED_W + RECIP_W;
   localparam int CAP_SHIFT  = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USED_W = 2 + PHASE_W + ELAPSED_W + CAP_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [LEVEL_W-1:0]  CHARGED_RST = LEVEL_W'(1023);
   localparam logic [LEVEL_W-1:0]  UPPER_RST   = LEVEL_W'(900);
   localparam logic [LEVEL_W-1:0]  LOWER_RST   = LEVEL_W'(10);
   localparam logic [SETTLE_W-1:0] SETTLE_RST  = SETTLE_W'(10);
   localparam logic [WAIT_W-1:0]   WAIT_RST    = WAIT_W'(1000);
   localparam logic [RECIP_W-1:0]  RECIP_RST   = RECIP_W'(4294967);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CHARGED_LEVEL   = 3'd0,
      REG_UPPER_THRESHOLD = 3'd1,
      REG_LOWER_THRESHOLD = 3'd2,
      REG_SETTLE_TICKS    = 3'd3,
      REG_WAIT_TICKS      = 3'd4,
      REG_RECIP_RES       = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_BOOT_SETTLE = 3'd0,
      ST_CHG_SETTLE  = 3'd1,
      ST_CHG_WAIT    = 3'd2,
      ST_DIS_SETTLE  = 3'd3,
      ST_MEAS_UP     = 3'd4,
      ST_MEAS_DOWN   = 3'd5,
      ST_WAIT        = 3'd6
   } step_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_CHARGING    = 2'd0,
      PH_DISCHARGING = 2'd1,
      PH_MEASURING   = 2'd2,
      PH_WAITING     = 2'd3
   } phase_type;

   function automatic phase_type phase_of(input step_type s);
      phase_type p;
      case (s)
         ST_BOOT_SETTLE, ST_DIS_SETTLE: p = PH_DISCHARGING;
         ST_MEAS_UP, ST_MEAS_DOWN:      p = PH_MEASURING;
         ST_WAIT:                       p = PH_WAITING;
         default:                       p = PH_CHARGING;
      endcase
      return p;
   endfunction

endpackage

### src/rc_capacitance_meter_sequencer.sv
// ----------------------------------------------------------------------------
// RC capacitance meter sequencer
// Steps the charge, discharge, timing and idle phases of an RC measurement.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one transaction per millisecond tick, carrying the ADC
//    sample of the capacitor voltage in req_tdata[9:0].
//  - rsp_ channel: exactly one transaction per request, showing the drive
//    pins, phase and, on completion ticks, the elapsed ticks and the Q16.16
//    capacitance (elapsed * recip_resistance >> 16, saturated to 32 bits).
//    rsp_tuser flags the tick on which a measurement completes.
//  - csr_ port: write-only register file; index 0 charged level, 1 upper
//    threshold, 2 lower threshold, 3 settle ticks, 4 wait ticks, 5 reciprocal
//    resistance (2^32 / ohms). Write it only while no transaction is in flight.
// Path: a request is captured in the input register, then the sequencer
//    update is registered into the response register.
// Throughput: one transaction per cycle while rsp_tready is high; the sequencer
//    update and one 24x32 product fit between the input and response registers.
// Reset: synchronous; the sequencer starts in the boot discharge settle step
//    with both drives off and the registers at their reset values.
// Stall: when rsp_tready is low the response holds, the input register
//    keeps one more transaction, and req_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "rc_capacitance_meter_sequencer_assert.svh"

module rc_capacitance_meter_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rccm_pkg::REQ_DATA_W-1:0]     req_tdata,  // [9:0] adc_sample
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rccm_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [0] charge_drive,
                                                           // [1] discharge_drive,
                                                           // [3:2] phase,
                                                           // [27:4] elapsed_ticks,
                                                           // [59:28] capacitance_q16
   output logic                                rsp_tuser,  // [0] result_valid
   // configuration port
   input  logic                                csr_we,
   input  logic [rccm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rccm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [rccm_pkg::LEVEL_W-1:0]  charged_level_ff;
   logic [rccm_pkg::LEVEL_W-1:0]  upper_threshold_ff;
   logic [rccm_pkg::LEVEL_W-1:0]  lower_threshold_ff;
   logic [rccm_pkg::SETTLE_W-1:0] settle_ticks_ff;
   logic [rccm_pkg::WAIT_W-1:0]   wait_ticks_ff;
   logic [rccm_pkg::RECIP_W-1:0]  recip_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         charged_level_ff   <= rccm_pkg::CHARGED_RST;
         upper_threshold_ff <= rccm_pkg::UPPER_RST;
         lower_threshold_ff <= rccm_pkg::LOWER_RST;
         settle_ticks_ff    <= rccm_pkg::SETTLE_RST;
         wait_ticks_ff      <= rccm_pkg::WAIT_RST;
         recip_res_ff       <= rccm_pkg::RECIP_RST;
      end else if (csr_we) begin
         case (rccm_pkg::csr_index_type'(csr_addr))
            rccm_pkg::REG_CHARGED_LEVEL: begin
               charged_level_ff <= csr_wdata[rccm_pkg::LEVEL_W-1:0];
            end
            rccm_pkg::REG_UPPER_THRESHOLD: begin
               upper_threshold_ff <= csr_wdata[rccm_pkg::LEVEL_W-1:0];
            end
            rccm_pkg::REG_LOWER_THRESHOLD: begin
               lower_threshold_ff <= csr_wdata[rccm_pkg::LEVEL_W-1:0];
            end
            rccm_pkg::REG_SETTLE_TICKS: begin
               settle_ticks_ff <= csr_wdata[rccm_pkg::SETTLE_W-1:0];
            end
            rccm_pkg::REG_WAIT_TICKS: begin
               wait_ticks_ff <= csr_wdata[rccm_pkg::WAIT_W-1:0];
            end
            rccm_pkg::REG_RECIP_RES: begin
               recip_res_ff <= csr_wdata[rccm_pkg::RECIP_W-1:0];
            end
            default: begin
               // indexes past the register list are dropped
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Input register and stage advance
   // -------------------------------------------------------------------------
   logic                         in_valid_ff;
   logic [rccm_pkg::ADC_W-1:0]   in_sample_ff;
   logic                         rsp_valid_ff;
   logic                         advance;

   // The sequencer steps whenever a sample is held and the response slot
   // is free or being drained in this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata[rccm_pkg::ADC_W-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer state
   // -------------------------------------------------------------------------
   rccm_pkg::step_type            step_ff, step_in;
   logic [rccm_pkg::COUNT_W-1:0]  tick_ff, tick_in;
   logic [rccm_pkg::COUNT_W-1:0]  interval_ff, interval_in;
   logic                          charge_pin_ff, charge_pin_in;
   logic                          discharge_pin_ff, discharge_pin_in;
   logic                          done;
   logic                          settle_hit;
   logic                          wait_hit;

   assign settle_hit = tick_ff >= rccm_pkg::COUNT_W'(settle_ticks_ff);
   assign wait_hit   = tick_ff >= rccm_pkg::COUNT_W'(wait_ticks_ff);

   always_comb begin
      step_in          = step_ff;
      tick_in          = tick_ff;
      interval_in      = interval_ff;
      charge_pin_in    = charge_pin_ff;
      discharge_pin_in = discharge_pin_ff;
      done             = 1'b0;
      case (step_ff)
         rccm_pkg::ST_BOOT_SETTLE, rccm_pkg::ST_DIS_SETTLE: begin
            // charger off, settle, then switch the discharger on
            charge_pin_in = 1'b0;
            if (settle_hit) begin
               discharge_pin_in = 1'b1;
               tick_in          = '0;
               step_in          = (step_ff == rccm_pkg::ST_BOOT_SETTLE) ?
                                  rccm_pkg::ST_CHG_SETTLE : rccm_pkg::ST_MEAS_UP;
            end else begin
               tick_in = tick_ff + 1'b1;
            end
         end
         rccm_pkg::ST_CHG_WAIT: begin
            if (in_sample_ff >= charged_level_ff) begin
               tick_in = '0;
               step_in = rccm_pkg::ST_DIS_SETTLE;
            end
         end
         rccm_pkg::ST_MEAS_UP: begin
            if (in_sample_ff < upper_threshold_ff) begin
               interval_in = '0;
               step_in     = rccm_pkg::ST_MEAS_DOWN;
            end
         end
         rccm_pkg::ST_MEAS_DOWN: begin
            // saturating interval count; the sample below the lower level ends it
            if (interval_ff != rccm_pkg::COUNT_MAX) begin
               interval_in = interval_ff + 1'b1;
            end
            if (in_sample_ff < lower_threshold_ff) begin
               done    = 1'b1;
               tick_in = '0;
               step_in = rccm_pkg::ST_WAIT;
            end
         end
         rccm_pkg::ST_WAIT: begin
            if (wait_hit) begin
               tick_in = '0;
               step_in = rccm_pkg::ST_CHG_SETTLE;
            end else begin
               tick_in = tick_ff + 1'b1;
            end
         end
         default: begin
            // charge settle, and the one unused code
            step_in          = rccm_pkg::ST_CHG_SETTLE;
            discharge_pin_in = 1'b0;
            if (settle_hit) begin
               charge_pin_in = 1'b1;
               tick_in       = '0;
               step_in       = rccm_pkg::ST_CHG_WAIT;
            end else begin
               tick_in = tick_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= rccm_pkg::ST_BOOT_SETTLE;
         tick_ff          <= '0;
         interval_ff      <= '0;
         charge_pin_ff    <= 1'b0;
         discharge_pin_ff <= 1'b0;
      end else if (advance) begin
         step_ff          <= step_in;
         tick_ff          <= tick_in;
         interval_ff      <= interval_in;
         charge_pin_ff    <= charge_pin_in;
         discharge_pin_ff <= discharge_pin_in;
      end
   end

   // -------------------------------------------------------------------------
   // Capacitance: elapsed * reciprocal resistance, drop 16 fraction bits,
   // saturate to 32 bits.
   // -------------------------------------------------------------------------
   logic [rccm_pkg::ELAPSED_W-1:0] elapsed;
   logic [rccm_pkg::PROD_W-1:0]    product;
   logic [rccm_pkg::CAP_W-1:0]     cap;

   assign elapsed = interval_in;
   assign product = rccm_pkg::PROD_W'(elapsed) * rccm_pkg::PROD_W'(recip_res_ff);
   assign cap     = (|product[rccm_pkg::PROD_W-1:rccm_pkg::CAP_SHIFT+rccm_pkg::CAP_W]) ?
                    {rccm_pkg::CAP_W{1'b1}} :
                    product[rccm_pkg::CAP_SHIFT+rccm_pkg::CAP_W-1:rccm_pkg::CAP_SHIFT];

   // -------------------------------------------------------------------------
   // Response register
   // -------------------------------------------------------------------------
   logic                            rsp_charge_ff;
   logic                            rsp_discharge_ff;
   rccm_pkg::phase_type             rsp_phase_ff;
   logic                            rsp_done_ff;
   logic [rccm_pkg::ELAPSED_W-1:0]  rsp_elapsed_ff;
   logic [rccm_pkg::CAP_W-1:0]      rsp_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_charge_ff    <= charge_pin_in;
         rsp_discharge_ff <= discharge_pin_in;
         rsp_phase_ff     <= rccm_pkg::phase_of(step_in);
         rsp_done_ff      <= done;
         rsp_elapsed_ff   <= done ? elapsed : '0;
         rsp_cap_ff       <= done ? cap : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tdata  = {{(rccm_pkg::RSP_DATA_W-rccm_pkg::RSP_USED_W){1'b0}},
                        rsp_cap_ff, rsp_elapsed_ff, rsp_phase_ff,
                        rsp_discharge_ff, rsp_charge_ff};

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `RCCM_ASSERT_ALWAYS(a_drives_exclusive, !(charge_pin_ff && discharge_pin_ff),
      "charge and discharge drives both on")
   `RCCM_ASSERT_ALWAYS(a_chg_wait_drive,
      (step_ff != rccm_pkg::ST_CHG_WAIT) || (charge_pin_ff && !discharge_pin_ff),
      "charge wait step without the charger on")
   `RCCM_ASSERT_ALWAYS(a_done_in_wait,
      !(rsp_valid_ff && rsp_done_ff) || (rsp_phase_ff == rccm_pkg::PH_WAITING),
      "completed measurement not followed by the wait phase")
   `RCCM_ASSERT_NEXT(a_held_sample_kept, in_valid_ff && !advance, in_valid_ff,
      "held sample dropped while the response was stalled")

endmodule

### tb/rc_capacitance_meter_sequencer_test.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// RC capacitance meter sequencer testbench
// Streams ADC ticks shaped to walk the boot discharge, charge, discharge,
// timing and idle steps under several register settings, predicts every
// response transaction and compares it field by field, in order.
// ----------------------------------------------------------------------------
module rc_capacitance_meter_sequencer_test;

   // Sequencer state plus the register file it runs under.
   typedef struct packed {
      rccm_pkg::step_type step;
      logic [23:0]        ticks;
      logic [23:0]        interval;
      logic               charge_pin;
      logic               discharge_pin;
      logic [9:0]         charged;
      logic [9:0]         upper;
      logic [9:0]         lower;
      logic [15:0]        settle;
      logic [23:0]        wait_len;
      logic [31:0]        recip;
   } meter_type;

   // One response transaction as predicted.
   typedef struct packed {
      logic                charge;
      logic                discharge;
      rccm_pkg::phase_type phase;
      logic                done;
      logic [23:0]         elapsed;
      logic [31:0]         cap;
   } reading_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [rccm_pkg::REQ_DATA_W-1:0]   req_tdata = '0;   // [9:0] adc_sample
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [rccm_pkg::RSP_DATA_W-1:0]   rsp_tdata;        // [0] charge_drive,
                                                        // [1] discharge_drive,
                                                        // [3:2] phase,
                                                        // [27:4] elapsed_ticks,
                                                        // [59:28] capacitance_q16
   logic                              rsp_tuser;        // [0] result_valid
   logic                              csr_we = 1'b0;
   logic [rccm_pkg::CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [rccm_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   meter_type   plan_model;       // shapes the stimulus ahead of the block
   meter_type   live_model;       // advanced on each accepted request
   logic [9:0]  adc_backlog[$];   // samples waiting for the request driver
   reading_type pending_readings[$];
   int          samples_queued = 0;
   int          samples_taken = 0;
   int          readings_seen = 0;
   int          mismatch_count = 0;
   bit          calm = 1'b0;      // no idling on either side

   rc_capacitance_meter_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic meter_type fresh_meter();
      meter_type m;
      m.step          = rccm_pkg::ST_BOOT_SETTLE;
      m.ticks         = '0;
      m.interval      = '0;
      m.charge_pin    = 1'b0;
      m.discharge_pin = 1'b0;
      m.charged       = 10'd1023;
      m.upper         = 10'd900;
      m.lower         = 10'd10;
      m.settle        = 16'd10;
      m.wait_len      = 24'd1000;
      m.recip         = 32'd4294967;
      return m;
   endfunction

   function automatic void apply_reg(inout meter_type m,
                                     input rccm_pkg::csr_index_type idx,
                                     input logic [31:0] value);
      case (idx)
         rccm_pkg::REG_CHARGED_LEVEL:   m.charged  = value[9:0];
         rccm_pkg::REG_UPPER_THRESHOLD: m.upper    = value[9:0];
         rccm_pkg::REG_LOWER_THRESHOLD: m.lower    = value[9:0];
         rccm_pkg::REG_SETTLE_TICKS:    m.settle   = value[15:0];
         rccm_pkg::REG_WAIT_TICKS:      m.wait_len = value[23:0];
         rccm_pkg::REG_RECIP_RES:       m.recip    = value;
         default: ;
      endcase
   endfunction

   // Advance one millisecond tick and report the state after the update.
   function automatic void advance_meter(inout meter_type m, input logic [9:0] sample,
                                         output reading_type r);
      logic [63:0] prod;
      r = '0;
      case (m.step)
         rccm_pkg::ST_BOOT_SETTLE, rccm_pkg::ST_DIS_SETTLE: begin
            m.charge_pin = 1'b0;
            if (m.ticks >= 24'(m.settle)) begin
               m.discharge_pin = 1'b1;
               m.ticks = '0;
               // the boot discharge skips the measurement
               if (m.step == rccm_pkg::ST_BOOT_SETTLE) m.step = rccm_pkg::ST_CHG_SETTLE;
               else m.step = rccm_pkg::ST_MEAS_UP;
            end else begin
               m.ticks = m.ticks + 1'b1;
            end
         end
         rccm_pkg::ST_CHG_WAIT: begin
            if (sample >= m.charged) begin
               m.ticks = '0;
               m.step = rccm_pkg::ST_DIS_SETTLE;
            end
         end
         rccm_pkg::ST_MEAS_UP: begin
            if (sample < m.upper) begin
               m.interval = '0;
               m.step = rccm_pkg::ST_MEAS_DOWN;
            end
         end
         rccm_pkg::ST_MEAS_DOWN: begin
            if (m.interval != '1) m.interval = m.interval + 1'b1;
            if (sample < m.lower) begin
               r.done = 1'b1;
               r.elapsed = m.interval;
               prod = (64'(m.interval) * 64'(m.recip)) >> 16;
               r.cap = (prod[63:32] != 0) ? '1 : prod[31:0];
               m.ticks = '0;
               m.step = rccm_pkg::ST_WAIT;
            end
         end
         rccm_pkg::ST_WAIT: begin
            if (m.ticks >= m.wait_len) begin
               m.ticks = '0;
               m.step = rccm_pkg::ST_CHG_SETTLE;
            end else begin
               m.ticks = m.ticks + 1'b1;
            end
         end
         default: begin
            m.step = rccm_pkg::ST_CHG_SETTLE;
            m.discharge_pin = 1'b0;
            if (m.ticks >= 24'(m.settle)) begin
               m.charge_pin = 1'b1;
               m.ticks = '0;
               m.step = rccm_pkg::ST_CHG_WAIT;
            end else begin
               m.ticks = m.ticks + 1'b1;
            end
         end
      endcase
      r.charge = m.charge_pin;
      r.discharge = m.discharge_pin;
      case (m.step)
         rccm_pkg::ST_BOOT_SETTLE, rccm_pkg::ST_DIS_SETTLE: r.phase = rccm_pkg::PH_DISCHARGING;
         rccm_pkg::ST_MEAS_UP, rccm_pkg::ST_MEAS_DOWN:      r.phase = rccm_pkg::PH_MEASURING;
         rccm_pkg::ST_WAIT:                                 r.phase = rccm_pkg::PH_WAITING;
         default:                                           r.phase = rccm_pkg::PH_CHARGING;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus shaping
   // -------------------------------------------------------------------------
   // Bias the sample toward the level that moves the planned step on.
   // end_odds: 1-in-N chance to force the end of the timing; 0 keeps timing running.
   function automatic logic [9:0] pick_sample(input meter_type m, input int end_odds);
      logic [9:0] s;
      s = 10'($urandom_range(1023, 0));
      case (m.step)
         rccm_pkg::ST_CHG_WAIT:
            if ($urandom_range(3, 0) == 0) s = 10'($urandom_range(1023, int'(m.charged)));
         rccm_pkg::ST_MEAS_UP:
            if (m.upper != 0 && $urandom_range(3, 0) == 0)
               s = 10'($urandom_range(int'(m.upper) - 1, 0));
         rccm_pkg::ST_MEAS_DOWN:
            if (m.lower != 0 && end_odds != 0 && $urandom_range(end_odds, 1) == 1)
               s = 10'($urandom_range(int'(m.lower) - 1, 0));
            else if (end_odds == 0 || $urandom_range(1, 0) == 0)
               s = 10'($urandom_range(1023, int'(m.lower)));
         default: ;
      endcase
      return s;
   endfunction

   task automatic push_sample(input logic [9:0] s);
      reading_type unused;
      advance_meter(plan_model, s, unused);
      adc_backlog.push_back(s);
      samples_queued++;
   endtask

   task automatic queue_ticks(input int count, input int end_odds);
      for (int i = 0; i < count; i++) push_sample(pick_sample(plan_model, end_odds));
   endtask

   // Hold until every queued sample is taken and every response is back.
   task automatic wait_quiet();
      while (samples_taken != samples_queued || pending_readings.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_reg(input rccm_pkg::csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      apply_reg(plan_model, idx, value);
      apply_reg(live_model, idx, value);
   endtask

   // Drain, then rewrite the whole register file.
   task automatic configure(input logic [9:0] charged, input logic [9:0] upper,
                            input logic [9:0] lower, input logic [15:0] settle,
                            input logic [23:0] wait_len, input logic [31:0] recip);
      wait_quiet();
      set_reg(rccm_pkg::REG_CHARGED_LEVEL, 32'(charged));
      set_reg(rccm_pkg::REG_UPPER_THRESHOLD, 32'(upper));
      set_reg(rccm_pkg::REG_LOWER_THRESHOLD, 32'(lower));
      set_reg(rccm_pkg::REG_SETTLE_TICKS, 32'(settle));
      set_reg(rccm_pkg::REG_WAIT_TICKS, 32'(wait_len));
      set_reg(rccm_pkg::REG_RECIP_RES, recip);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Request driver: one transaction per backlog entry, with random gaps and
   // the occasional full drain of outstanding responses.
   // -------------------------------------------------------------------------
   reading_type taken_reading;
   int          send_gap = 0;
   bit          drain_hold = 1'b0;
   int          sent_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_meter(live_model, req_tdata[9:0], taken_reading);
            pending_readings.push_back(taken_reading);
            samples_taken++;
         end
         if (drain_hold && pending_readings.size() == 0) drain_hold = 1'b0;
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (drain_hold || adc_backlog.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && pending_readings.size() != 0 &&
                         (sent_count == 300 || $urandom_range(149, 0) == 0)) begin
               // pause until the block has handed back everything
               drain_hold = 1'b1;
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= rccm_pkg::REQ_DATA_W'(adc_backlog.pop_front());
               req_tvalid <= 1'b1;
               sent_count++;
               if (!calm && $urandom_range(5, 0) == 0) send_gap = $urandom_range(7, 1);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side: random stall bursts, plus one long hold-off while the
   // request side keeps offering so the block backs up and drops req_tready.
   // -------------------------------------------------------------------------
   int rsp_hold_left = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && readings_seen >= 100 && adc_backlog.size() > 20) begin
         long_hold_done = 1'b1;
         rsp_hold_left = 59;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(9, 0) == 0) begin
         rsp_hold_left = $urandom_range(6, 0);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Response checker
   // -------------------------------------------------------------------------
   reading_type want;

   task automatic check_field(input string name, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         if (mismatch_count < 40)
            $display("%0t ns: %s expected %0h actual %0h", $time, name,
                     expected_value, actual_value);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            if (mismatch_count < 40)
               $display("%0t ns: response expected none actual %h/%b", $time,
                        rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("charge_drive", 32'(want.charge), 32'(rsp_tdata[0]));
            check_field("discharge_drive", 32'(want.discharge), 32'(rsp_tdata[1]));
            check_field("phase", 32'(want.phase), 32'(rsp_tdata[3:2]));
            check_field("result_valid", 32'(want.done), 32'(rsp_tuser));
            check_field("elapsed_ticks", 32'(want.elapsed), 32'(rsp_tdata[27:4]));
            check_field("capacitance_q16", want.cap, rsp_tdata[59:28]);
            readings_seen++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   logic [9:0] boot_ticks[6] = '{10'h3FF, 10'h000, 10'h155, 10'h2AA, 10'd1023, 10'd0};
   // With zero settle and wait: charge, discharge, time 2 ticks, then again
   // with a one-tick timing.
   logic [9:0] loop_ticks[15] = '{10'h155, 10'h2AA, 10'd0, 10'd1023, 10'h3FF,
                                  10'd1023, 10'd1022, 10'd5, 10'd0, 10'd0,
                                  10'd0, 10'd1023, 10'd0, 10'd0, 10'd0};

   initial begin
      plan_model = fresh_meter();
      live_model = fresh_meter();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // boot discharge counting under the reset register values
      foreach (boot_ticks[i]) push_sample(boot_ticks[i]);

      // full loop at the fastest timing, largest reciprocal resistance
      configure(10'd1023, 10'd1023, 10'd1, 16'd0, 24'd0, 32'hFFFF_FFFF);
      foreach (loop_ticks[i]) push_sample(loop_ticks[i]);

      // charging ends at once, any sample below full scale ends the timing,
      // zero reciprocal resistance
      configure(10'd0, 10'd1023, 10'd1023, 16'd1, 24'd1, 32'd0);
      queue_ticks(8, 1);

      // longer timing run at the largest reciprocal resistance
      configure(10'd512, 10'd1023, 10'd1, 16'd2, 24'd3, 32'hFFFF_FFFF);
      while (plan_model.step != rccm_pkg::ST_MEAS_DOWN) queue_ticks(1, 4);
      queue_ticks(40, 0);
      queue_ticks(4, 1);

      // register extremes: zero upper threshold never starts timing,
      // zero lower threshold never ends it, longest settle and wait
      configure(10'd1023, 10'd0, 10'd10, 16'hFFFF, 24'hFF_FFFF, $urandom);
      queue_ticks(12, 4);
      configure(10'd300, 10'd1023, 10'd0, 16'd0, 24'd0, $urandom);
      queue_ticks(12, 4);

      // random settings; the last one runs with no idling at all
      for (int p = 0; p < 10; p++) begin
         configure(($urandom_range(9, 0) == 0) ? 10'd1023 : 10'($urandom_range(1023, 300)),
                   10'($urandom_range(1023, 100)),
                   10'($urandom_range(200, 1)),
                   16'($urandom_range(5, 0)),
                   24'($urandom_range(12, 0)),
                   $urandom);
         if (p == 9) calm = 1'b1;
         queue_ticks(60, 4);
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### rc_capacitance_meter_sequencer.f
+incdir+src
src/rccm_pkg.sv
src/rc_capacitance_meter_sequencer.sv
tb/rc_capacitance_meter_sequencer_test.sv
